/* hw/rtl/lmrq_pkg.sv */
// Package for the Lamport mutual-exclusion request queue.
// Holds the table entry type, the codes of events and results, and the sequencer states.
// Used by the top, the cell and the sequencer; depends on nothing.
`default_nettype none

package lmrq_pkg;

    localparam int TABLE_DEPTH = 4;
    localparam int STEP_W = 2;
    localparam logic [31:0] CLOCK_TOP = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        OP_INTERNAL     = 3'd0,
        OP_LOCAL_REQ    = 3'd1,
        OP_LOCAL_REL    = 3'd2,
        OP_REMOTE_REQ   = 3'd3,
        OP_REMOTE_REPLY = 3'd4,
        OP_REMOTE_REL   = 3'd5
    } t_opcode;

    typedef enum logic [1:0] {
        BC_NONE    = 2'd0,
        BC_REQUEST = 2'd1,
        BC_RELEASE = 2'd2
    } t_bcast;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NO_ENTRY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_REMOVE = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_LOOKUP = 2'd1,
        S_MODIFY = 2'd2,
        S_RESULT = 2'd3
    } t_state;

    typedef struct packed {
        logic        valid;
        logic [1:0]  node;
        logic [31:0] stamp;
    } t_entry;

    // Control from the sequencer to the ring of table cells.
    typedef struct packed {
        logic   shift;
        t_entry wb;
    } t_chain_ctl;

endpackage

`default_nettype wire

/* hw/rtl/lmrq_if.sv */
// Handshake channels of the request queue: event items in, result items out.
// Both carry valid, ready and the payload fields; no package is needed.
`default_nettype none

interface lmrq_evt_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [31:0] stamp;
    logic [1:0]  sender;

    modport source (output valid, output opcode, output stamp, output sender, input ready);
    modport sink   (input valid, input opcode, input stamp, input sender, output ready);
endinterface

interface lmrq_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] clock_now;
    logic        send_reply;
    logic [1:0]  send_broadcast;
    logic        grant;
    logic [1:0]  status;

    modport source (output valid, output clock_now, output send_reply, output send_broadcast,
                    output grant, output status, input ready);
    modport sink   (input valid, input clock_now, input send_reply, input send_broadcast,
                    input grant, input status, output ready);
endinterface

`default_nettype wire

/* hw/rtl/lamport_mutex_request_queue_top.sv */
// Top level of the Lamport mutual-exclusion request queue: node id register and table ring.
// Depends on lmrq_pkg, lmrq_if, lmrq_cell and lmrq_ctrl.
`default_nettype none

// One node of Lamport's distributed mutual exclusion. Each event item yields exactly one
// result item carrying the new logical clock, the reply and broadcast requests, the grant
// and a status code. The request table is a ring of four cells that the sequencer turns
// one entry a cycle: an item is accepted, then the ring makes one turn to apply the change
// and find the head of the table, and the result state loads the result, after which the
// block is ready again. Requests that may insert into the table (an eligible local request
// or a remote request) first take one more turn to look up the node. A result not yet
// taken holds the block in its last step only until the output register frees. The user
// must write the node id register only while idle; the block does not enforce it.
module lamport_mutex_request_queue_top #(
    parameter int NODE_COUNT = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_wdata,
    lmrq_evt_if.sink        i_evt,
    lmrq_res_if.source      o_res
);

    logic [1:0]           r_own_id;
    lmrq_pkg::t_chain_ctl chain_ctl;
    lmrq_pkg::t_entry     ring [lmrq_pkg::TABLE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id <= '0;
        end else if (i_cfg_we) begin
            r_own_id <= i_cfg_wdata;
        end
    end

    // Entries move towards cell 0; the sequencer reads cell 0 and feeds the last cell.
    for (genvar g = 0; g < lmrq_pkg::TABLE_DEPTH; g++) begin : g_ring
        lmrq_pkg::t_entry feed;
        if (g == lmrq_pkg::TABLE_DEPTH - 1) begin : g_last
            assign feed = chain_ctl.wb;
        end else begin : g_mid
            assign feed = ring[g + 1];
        end
        lmrq_cell u_slot (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (chain_ctl.shift),
            .i_entry (feed),
            .o_entry (ring[g])
        );
    end

    lmrq_ctrl #(
        .NODE_COUNT (NODE_COUNT)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_own_id (r_own_id),
        .i_evt    (i_evt),
        .o_res    (o_res),
        .i_head   (ring[0]),
        .o_chain  (chain_ctl)
    );

endmodule

`default_nettype wire

/* hw/rtl/lmrq_cell.sv */
// One cell of the request table ring: holds a single entry and passes it on when shifted.
// Depends on lmrq_pkg for the entry type.
`default_nettype none

module lmrq_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_shift,
    input  wire lmrq_pkg::t_entry i_entry,
    output lmrq_pkg::t_entry     o_entry
);

    logic        r_valid;
    logic [1:0]  r_node;
    logic [31:0] r_stamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_entry.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_node  <= i_entry.node;
            r_stamp <= i_entry.stamp;
        end
    end

    assign o_entry = '{valid: r_valid, node: r_node, stamp: r_stamp};

endmodule

`default_nettype wire

/* hw/rtl/lmrq_ctrl.sv */
// Sequencer of the request queue: logical clock, flags, reply marks and the result register.
// Walks the table ring one entry a cycle. Depends on lmrq_pkg and lmrq_if.
`default_nettype none

module lmrq_ctrl #(
    parameter int NODE_COUNT = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [1:0]        i_own_id,
    lmrq_evt_if.sink               i_evt,
    lmrq_res_if.source             o_res,
    input  wire lmrq_pkg::t_entry  i_head,
    output lmrq_pkg::t_chain_ctl   o_chain
);

    lmrq_pkg::t_state  r_state, n_state;
    logic [lmrq_pkg::STEP_W-1:0] r_step, n_step;
    logic [31:0]       r_clock, n_clock;
    logic              r_pending, n_pending;
    logic              r_in_cs, n_in_cs;
    logic [NODE_COUNT-1:0] r_marks, n_marks;

    lmrq_pkg::t_action r_act, n_act;
    logic [2:0]        r_op, n_op;
    logic [1:0]        r_key_node, n_key_node;
    logic [31:0]       r_key_stamp, n_key_stamp;
    logic              r_found, n_found;
    logic              r_free, n_free;
    logic              r_done, n_done;
    logic              r_best_valid, n_best_valid;
    logic [1:0]        r_best_node, n_best_node;
    logic [31:0]       r_best_stamp, n_best_stamp;
    logic              r_reply, n_reply;

    logic              r_out_valid, n_out_valid;
    logic [31:0]       r_out_clock, n_out_clock;
    logic              r_out_reply, n_out_reply;
    lmrq_pkg::t_bcast  r_out_bcast, n_out_bcast;
    logic              r_out_grant, n_out_grant;
    lmrq_pkg::t_status r_out_status, n_out_status;

    logic              accept;
    logic              is_remote;
    logic              remote_ok;
    logic [31:0]       clk_max;
    logic              hit;
    lmrq_pkg::t_entry  mod_entry;
    logic [NODE_COUNT-1:0] need;
    logic              fin_pending;
    logic [NODE_COUNT-1:0] fin_marks;
    lmrq_pkg::t_bcast  fin_bcast;
    lmrq_pkg::t_status fin_status;
    logic              fin_grant;

    assign i_evt.ready = (r_state == lmrq_pkg::S_IDLE);
    assign accept      = i_evt.valid && i_evt.ready;
    assign is_remote   = (i_evt.opcode == lmrq_pkg::OP_REMOTE_REQ)
                      || (i_evt.opcode == lmrq_pkg::OP_REMOTE_REPLY)
                      || (i_evt.opcode == lmrq_pkg::OP_REMOTE_REL);
    assign remote_ok   = (i_evt.sender != i_own_id) && (int'(i_evt.sender) < NODE_COUNT);
    assign clk_max     = (is_remote && (i_evt.stamp > r_clock)) ? i_evt.stamp : r_clock;
    assign hit         = i_head.valid && (i_head.node == r_key_node);
    // A node id at or above the node count shifts out and leaves every node as a peer.
    assign need        = {NODE_COUNT{1'b1}} & ~(NODE_COUNT'(1) << i_own_id);

    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        n_clock      = r_clock;
        n_pending    = r_pending;
        n_in_cs      = r_in_cs;
        n_marks      = r_marks;
        n_act        = r_act;
        n_op         = r_op;
        n_key_node   = r_key_node;
        n_key_stamp  = r_key_stamp;
        n_found      = r_found;
        n_free       = r_free;
        n_done       = r_done;
        n_best_valid = r_best_valid;
        n_best_node  = r_best_node;
        n_best_stamp = r_best_stamp;
        n_reply      = r_reply;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out_clock  = r_out_clock;
        n_out_reply  = r_out_reply;
        n_out_bcast  = r_out_bcast;
        n_out_grant  = r_out_grant;
        n_out_status = r_out_status;
        o_chain      = '{shift: 1'b0, wb: i_head};
        mod_entry    = i_head;
        fin_pending  = r_pending;
        fin_marks    = r_marks;
        fin_bcast    = lmrq_pkg::BC_NONE;
        fin_status   = lmrq_pkg::ST_OK;
        fin_grant    = 1'b0;

        case (r_state)
            lmrq_pkg::S_IDLE: begin
                if (accept) begin
                    n_clock      = (clk_max == lmrq_pkg::CLOCK_TOP) ? lmrq_pkg::CLOCK_TOP
                                                                     : clk_max + 32'd1;
                    n_op         = i_evt.opcode;
                    n_act        = lmrq_pkg::ACT_NONE;
                    n_key_node   = i_evt.sender;
                    n_key_stamp  = i_evt.stamp;
                    n_found      = 1'b0;
                    n_free       = 1'b0;
                    n_done       = 1'b0;
                    n_best_valid = 1'b0;
                    n_reply      = 1'b0;
                    n_step       = '0;
                    case (i_evt.opcode)
                        lmrq_pkg::OP_LOCAL_REQ: begin
                            if (!r_pending && !r_in_cs) begin
                                n_act       = lmrq_pkg::ACT_INSERT;
                                n_key_node  = i_own_id;
                                n_key_stamp = n_clock;
                            end
                        end
                        lmrq_pkg::OP_LOCAL_REL: begin
                            n_act      = lmrq_pkg::ACT_REMOVE;
                            n_key_node = i_own_id;
                            n_pending  = 1'b0;
                            n_in_cs    = 1'b0;
                            n_marks    = '0;
                        end
                        lmrq_pkg::OP_REMOTE_REQ: begin
                            if (remote_ok) begin
                                n_act   = lmrq_pkg::ACT_INSERT;
                                n_reply = 1'b1;
                            end
                        end
                        lmrq_pkg::OP_REMOTE_REPLY: begin
                            if (remote_ok && r_pending) begin
                                n_marks = r_marks | (NODE_COUNT'(1) << i_evt.sender);
                            end
                        end
                        lmrq_pkg::OP_REMOTE_REL: begin
                            if (remote_ok) begin
                                n_act = lmrq_pkg::ACT_REMOVE;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_state = (n_act == lmrq_pkg::ACT_INSERT) ? lmrq_pkg::S_LOOKUP
                                                              : lmrq_pkg::S_MODIFY;
                end
            end

            // First turn of the ring: find the key node and whether a slot is free.
            lmrq_pkg::S_LOOKUP: begin
                o_chain.shift = 1'b1;
                n_found       = r_found || hit;
                n_free        = r_free || !i_head.valid;
                n_step        = r_step + 1'b1;
                if (r_step == lmrq_pkg::STEP_W'(lmrq_pkg::TABLE_DEPTH - 1)) begin
                    n_state = lmrq_pkg::S_MODIFY;
                end
            end

            // Last turn: apply any change and track the head of the amended table.
            lmrq_pkg::S_MODIFY: begin
                if (r_act == lmrq_pkg::ACT_INSERT) begin
                    if (r_found) begin
                        if (hit) begin
                            mod_entry.stamp = r_key_stamp;
                        end
                    end else if (r_free && !r_done && !i_head.valid) begin
                        mod_entry = '{valid: 1'b1, node: r_key_node, stamp: r_key_stamp};
                        n_done    = 1'b1;
                    end
                end else if (r_act == lmrq_pkg::ACT_REMOVE) begin
                    if (hit) begin
                        mod_entry.valid = 1'b0;
                        n_found         = 1'b1;
                    end
                end
                o_chain = '{shift: 1'b1, wb: mod_entry};
                if (mod_entry.valid && (!r_best_valid || (mod_entry.stamp < r_best_stamp)
                        || ((mod_entry.stamp == r_best_stamp)
                            && (mod_entry.node < r_best_node)))) begin
                    n_best_valid = 1'b1;
                    n_best_node  = mod_entry.node;
                    n_best_stamp = mod_entry.stamp;
                end
                n_step = r_step + 1'b1;
                if (r_step == lmrq_pkg::STEP_W'(lmrq_pkg::TABLE_DEPTH - 1)) begin
                    n_state = lmrq_pkg::S_RESULT;
                end
            end

            lmrq_pkg::S_RESULT: begin
                if (r_act == lmrq_pkg::ACT_INSERT) begin
                    if (!r_found && !r_free) begin
                        fin_status = lmrq_pkg::ST_FULL;
                    end else if (r_op == lmrq_pkg::OP_LOCAL_REQ) begin
                        fin_marks   = '0;
                        fin_pending = 1'b1;
                        fin_bcast   = lmrq_pkg::BC_REQUEST;
                    end
                end else if (r_act == lmrq_pkg::ACT_REMOVE) begin
                    if (!r_found) begin
                        fin_status = lmrq_pkg::ST_NO_ENTRY;
                    end else if (r_op == lmrq_pkg::OP_LOCAL_REL) begin
                        fin_bcast = lmrq_pkg::BC_RELEASE;
                    end
                end
                fin_grant = fin_pending && !r_in_cs && ((fin_marks & need) == need)
                         && r_best_valid && (r_best_node == i_own_id);
                if (!r_out_valid || o_res.ready) begin
                    n_pending    = fin_pending && !fin_grant;
                    n_in_cs      = r_in_cs || fin_grant;
                    n_marks      = fin_marks;
                    n_out_valid  = 1'b1;
                    n_out_clock  = r_clock;
                    n_out_reply  = r_reply;
                    n_out_bcast  = fin_bcast;
                    n_out_grant  = fin_grant;
                    n_out_status = fin_status;
                    n_state      = lmrq_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = lmrq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lmrq_pkg::S_IDLE;
            r_step      <= '0;
            r_clock     <= '0;
            r_pending   <= 1'b0;
            r_in_cs     <= 1'b0;
            r_marks     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_clock     <= n_clock;
            r_pending   <= n_pending;
            r_in_cs     <= n_in_cs;
            r_marks     <= n_marks;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act        <= n_act;
        r_op         <= n_op;
        r_key_node   <= n_key_node;
        r_key_stamp  <= n_key_stamp;
        r_found      <= n_found;
        r_free       <= n_free;
        r_done       <= n_done;
        r_best_valid <= n_best_valid;
        r_best_node  <= n_best_node;
        r_best_stamp <= n_best_stamp;
        r_reply      <= n_reply;
        r_out_clock  <= n_out_clock;
        r_out_reply  <= n_out_reply;
        r_out_bcast  <= n_out_bcast;
        r_out_grant  <= n_out_grant;
        r_out_status <= n_out_status;
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.clock_now      = r_out_clock;
    assign o_res.send_reply     = r_out_reply;
    assign o_res.send_broadcast = r_out_bcast;
    assign o_res.grant          = r_out_grant;
    assign o_res.status         = r_out_status;

    // The node is never both waiting for the section and inside it.
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_pending && r_in_cs))
        else $error("pending and in-section flags set together");

    // The modify turn of the ring starts from its first step.
    a_modify_starts_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lmrq_pkg::S_MODIFY) && ($past(r_state) != lmrq_pkg::S_MODIFY)
        |-> (r_step == '0))
        else $error("table pass started mid-turn");

    // A new result is only loaded out of the result state.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == lmrq_pkg::S_RESULT))
        else $error("result loaded outside the result state");

    // A release never coincides with a grant.
    a_no_grant_on_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_grant |-> (r_out_bcast != lmrq_pkg::BC_RELEASE))
        else $error("grant given together with a release");

endmodule

`default_nettype wire
